FILE: rtl/core/prtu_pkg.sv
package prtu_pkg;

  localparam logic [7:0]  DEAD_SCORE  = 8'd255;
  localparam logic [6:0]  SCORE_SCALE = 7'd100;
  // digits that follow the leading one in the weight accumulation
  localparam logic [2:0]  TAIL_DIGITS = 3'd4;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;

  typedef struct packed {
    logic load;    // latch the accepted request
    logic step;    // advance search and weight accumulation
    logic commit;  // write the record and load the result register
  } prtu_cmd_t;

  typedef struct packed {
    logic work_done;
    logic out_free;
  } prtu_stat_t;

endpackage

FILE: rtl/core/prtu_ctrl.sv
module prtu_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  prtu_pkg::prtu_stat_t  stat,
  output prtu_pkg::prtu_cmd_t   cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_WORK
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        cmd.step = 1'b1;
        // hold until the work is done and the result register can take the outcome
        if (stat.work_done && stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/prtu_dp.sv
module prtu_dp #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [prtu_pkg::IN_DATA_W-1:0]      in_tdata,
  input  prtu_pkg::prtu_cmd_t                 cmd,
  output prtu_pkg::prtu_stat_t                stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [prtu_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);

  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);

  // request fields
  logic [7:0]       id_r;
  logic [7:0]       score_low;
  logic [7:0]       score_high;
  logic             dead_r;
  logic [31:0]      digits_r;
  logic [2:0]       dig_left_r;
  logic [15:0]      weight_r;
  logic [15:0]      score_r;

  // table state
  logic [7:0]       id_mem [TABLE_SIZE];
  logic [CNT_W-1:0] count_r;
  logic [15:0]      msg_r;

  // search pipeline
  logic [CNT_W-1:0] iss_r;
  logic             cmp_valid_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [7:0]       rd_id_r;
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic             srch_done_r;

  logic             hit;
  logic             issue;
  logic             has_room;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] count_nxt;
  logic [8:0]       slot_ext;
  logic [8:0]       count_ext;
  logic             out_valid_r;

  logic [58:0]      res_nxt;
  logic [58:0]      res_r;
  logic             ign_r;

  assign score_low  = in_tdata[63:56];
  assign score_high = in_tdata[55:48];

  assign hit      = cmp_valid_r && (rd_id_r == id_r);
  assign issue    = cmd.step && !srch_done_r && !hit && (iss_r < count_r);
  assign has_room = count_r < CNT_W'(TABLE_SIZE);

  always_comb begin
    if (found_r) begin
      wr_idx = found_idx_r;
    end else if (has_room) begin
      wr_idx = count_r[IDX_W-1:0];
    end else begin
      wr_idx = IDX_W'(TABLE_SIZE - 1);
    end
    count_nxt = count_r;
    if (!dead_r && !found_r && has_room) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  assign slot_ext  = 9'(wr_idx);
  assign count_ext = 9'(count_nxt);

  always_comb begin
    res_nxt = '0;
    res_nxt[10:6] = count_ext[4:0];
    if (dead_r) begin
      res_nxt[26:11] = msg_r;
    end else begin
      res_nxt[3:0]   = slot_ext[3:0];
      res_nxt[4]     = !found_r;
      res_nxt[5]     = !found_r && !has_room;
      res_nxt[26:11] = msg_r + 16'd1;
      res_nxt[42:27] = weight_r;
      res_nxt[58:43] = score_r;
    end
  end

  // id store: one read port for the scan, one write port for the update
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_id_r <= id_mem[iss_r[IDX_W-1:0]];
    end
    if (cmd.commit && !dead_r) begin
      id_mem[wr_idx] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r       <= in_tdata[7:0];
      dead_r     <= (score_low == prtu_pkg::DEAD_SCORE);
      weight_r   <= 16'(in_tdata[15:8]);
      digits_r   <= in_tdata[47:16];
      dig_left_r <= prtu_pkg::TAIL_DIGITS;
      score_r    <= 16'(score_high) * 16'(prtu_pkg::SCORE_SCALE) + 16'(score_low);
    end else if (cmd.step && dig_left_r != 3'd0) begin
      // Horner step: weight = weight * 10 + next digit
      weight_r   <= (weight_r << 3) + (weight_r << 1) + 16'(digits_r[7:0]);
      digits_r   <= {8'd0, digits_r[31:8]};
      dig_left_r <= dig_left_r - 3'd1;
    end
    if (issue) begin
      cmp_idx_r <= iss_r[IDX_W-1:0];
    end
    if (cmd.step && !srch_done_r && hit) begin
      found_idx_r <= cmp_idx_r;
    end
    if (cmd.commit) begin
      res_r <= res_nxt;
      ign_r <= dead_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      msg_r       <= '0;
      iss_r       <= '0;
      cmp_valid_r <= 1'b0;
      found_r     <= 1'b0;
      srch_done_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        iss_r       <= '0;
        cmp_valid_r <= 1'b0;
        found_r     <= 1'b0;
        srch_done_r <= (score_low == prtu_pkg::DEAD_SCORE);
      end else if (cmd.step && !srch_done_r) begin
        if (hit) begin
          found_r     <= 1'b1;
          srch_done_r <= 1'b1;
          cmp_valid_r <= 1'b0;
        end else if (iss_r < count_r) begin
          iss_r       <= iss_r + CNT_W'(1);
          cmp_valid_r <= 1'b1;
        end else begin
          srch_done_r <= 1'b1;
          cmp_valid_r <= 1'b0;
        end
      end
      if (cmd.commit) begin
        count_r     <= count_nxt;
        msg_r       <= res_nxt[26:11];
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.work_done = srch_done_r && (dig_left_r == 3'd0);
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ign_r;
  assign out_tdata  = {5'd0, res_r};

endmodule

FILE: rtl/core/peer_record_table_update.sv
// Channel  Direction  Ports                      Contents
// in_      slave      tvalid tready tdata[63:0]  one received peer message
// out_     master     tvalid tready tdata[63:0]  update outcome for that message
//                     tuser[0]                   ignored (dead sender)
//
// The result register loads once the id scan and the weight accumulation are done
// and the output is free; the next request is taken the cycle after that commit.
// The id scan reads one stored id per cycle from a table with separate read and
// write ports, gets each id the cycle after its address, and stops at the first
// match or the fill count. The weight is accumulated one digit per cycle.
// A waiting result does not block the next request; only its commit waits.
// Reset empties the table by clearing the fill count; no clearing pass runs.
module peer_record_table_update #(
  parameter int TABLE_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sender_id, digit_ten_thousands, digit_thousands, digit_hundreds,
  // digit_tens, digit_units, score_high, score_low (8 bits each)
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot[3:0], is_new[4], evicted[5], entry_count[10:6], message_total[26:11],
  // stored_weight[42:27], stored_score[58:43], zero fill[63:59]
  output logic [63:0] out_tdata,
  // ignored[0]
  output logic        out_tuser
);

  prtu_pkg::prtu_cmd_t  cmd;
  prtu_pkg::prtu_stat_t stat;

  prtu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  prtu_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
